// File: design/pi_period_controller_defines.svh
// Assertion macros for the blocks that check themselves; the controller uses them.
`ifndef PI_PERIOD_CONTROLLER_DEFINES_SVH
`define PI_PERIOD_CONTROLLER_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define PIPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define PIPC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/pipc_pkg.sv
package pipc_pkg;

	// sample and integrator geometry
	localparam int SAMPLE_BITS = 10;
	localparam int FRAC_BITS   = 16;
	localparam int VOLT_SPAN   = 5;
	localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;

	// |ref - fb| * VOLT_SPAN stays below 8 * 2^SAMPLE_BITS
	localparam int SCALED_W = SAMPLE_BITS + 3;
	localparam int ERR_W    = 4;
	localparam int ERR_MAG_W = 3;

	localparam int ACC_W   = 32;
	localparam int WHOLE_W = 16;
	localparam int GAIN_W  = 8;
	localparam int KI_W    = 16;
	localparam int PERIOD_W = 16;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INTEG_GAIN     = 3'd1,
		REG_PERIOD_BASE    = 3'd2,
		REG_PERIOD_FLOOR   = 3'd3,
		REG_PERIOD_CEILING = 3'd4
	} cfg_reg_t;

	localparam logic [GAIN_W-1:0]   PROP_GAIN_RST      = 8'd9;
	localparam logic [KI_W-1:0]     INTEG_GAIN_RST     = 16'd1966;
	localparam logic [PERIOD_W-1:0] PERIOD_BASE_RST    = 16'd500;
	localparam logic [PERIOD_W-1:0] PERIOD_FLOOR_RST   = 16'd445;
	localparam logic [PERIOD_W-1:0] PERIOD_CEILING_RST = 16'd500;

endpackage

// File: design/pi_period_controller.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+-----------------------------------------------
// sample   | sample_valid / sample_ready | reference_sample, feedback_sample
// result   | result_valid / result_ready | period_top, integral_whole, error_volts, clamped
// config   | cfg_we (no wait)            | cfg_index, cfg_data
//
// One item per cycle unless result_ready stalls it; each item passes both registers.
// The input stage registers the whole-volt error; the integrator loop (accumulate,
// saturate, take whole part, clamp, revert) closes at the integral register, which
// loads with the result register, so each item sees the previous item's integral.
// Reset clears the integral, both valid flags and loads the register defaults.
// A stalled result holds in the output register; the input stage still takes
// one more item, and sample_ready drops only when both stages are full.
`include "pi_period_controller_defines.svh"

module pi_period_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic [pipc_pkg::SAMPLE_BITS-1:0]     reference_sample,
	input  logic [pipc_pkg::SAMPLE_BITS-1:0]     feedback_sample,

	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [pipc_pkg::PERIOD_W-1:0]        period_top,
	output logic signed [pipc_pkg::WHOLE_W-1:0]  integral_whole,
	output logic signed [pipc_pkg::ERR_W-1:0]    error_volts,
	output logic                                 clamped,

	input  logic                                 cfg_we,
	input  logic [pipc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pipc_pkg::CFG_W-1:0]           cfg_data
);

	localparam int SB  = pipc_pkg::SAMPLE_BITS;
	localparam int SW  = pipc_pkg::SCALED_W;
	localparam int AW  = pipc_pkg::ACC_W;
	localparam int WW  = pipc_pkg::WHOLE_W;
	localparam int PW  = pipc_pkg::PERIOD_W;
	localparam int EW  = pipc_pkg::ERR_W;
	localparam int MW  = pipc_pkg::ERR_MAG_W;
	localparam int PRODW = pipc_pkg::KI_W + EW + 1;   // ki * err
	localparam int PROPW = pipc_pkg::GAIN_W + EW + 1; // kp * err
	localparam int UW  = WW + 2;                      // controller output
	localparam int TW  = PW + 3;                      // period before clamp

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [pipc_pkg::GAIN_W-1:0] prop_gain_q;
	logic [pipc_pkg::KI_W-1:0]   integ_gain_q;
	logic [PW-1:0]               period_base_q;
	logic [PW-1:0]               period_floor_q;
	logic [PW-1:0]               period_ceiling_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= pipc_pkg::PROP_GAIN_RST;
			integ_gain_q     <= pipc_pkg::INTEG_GAIN_RST;
			period_base_q    <= pipc_pkg::PERIOD_BASE_RST;
			period_floor_q   <= pipc_pkg::PERIOD_FLOOR_RST;
			period_ceiling_q <= pipc_pkg::PERIOD_CEILING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pipc_pkg::REG_PROP_GAIN:      prop_gain_q      <= cfg_data[pipc_pkg::GAIN_W-1:0];
				pipc_pkg::REG_INTEG_GAIN:     integ_gain_q     <= cfg_data[pipc_pkg::KI_W-1:0];
				pipc_pkg::REG_PERIOD_BASE:    period_base_q    <= cfg_data[PW-1:0];
				pipc_pkg::REG_PERIOD_FLOOR:   period_floor_q   <= cfg_data[PW-1:0];
				pipc_pkg::REG_PERIOD_CEILING: period_ceiling_q <= cfg_data[PW-1:0];
				default: ; // drop writes past the register list
			endcase
		end
	end

	// ------------------------------------------------------------------
	// handshake: input stage and output register
	// ------------------------------------------------------------------
	logic s1_valid_q;
	logic out_valid_q;
	logic advance;
	logic take;

	// move the stage-1 item into the output register when that slot frees up
	assign advance      = s1_valid_q && (!out_valid_q || result_ready);
	assign sample_ready = !s1_valid_q || advance;
	assign take         = sample_valid && sample_ready;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take)
				s1_valid_q <= 1'b1;
			else if (advance)
				s1_valid_q <= 1'b0;

			if (advance)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: whole-volt error, trunc((ref - fb) * span / full scale)
	// ------------------------------------------------------------------
	logic signed [SB:0]     diff_c;
	logic [SB:0]            diff_mag_c;
	logic [SW-1:0]          scaled_c;
	logic [MW-1:0]          err_mag_c;
	logic signed [EW-1:0]   err_c;
	logic signed [EW-1:0]   err_s1;

	always_comb begin
		diff_c     = $signed({1'b0, reference_sample}) - $signed({1'b0, feedback_sample});
		diff_mag_c = diff_c[SB] ? (SB+1)'(-diff_c) : (SB+1)'(diff_c);
		scaled_c   = SW'(diff_mag_c) * SW'(pipc_pkg::VOLT_SPAN);
		// quotient by counting the multiples of full scale passed
		err_mag_c = '0;
		for (int k = 1; k <= pipc_pkg::VOLT_SPAN; k++) begin
			if (scaled_c >= SW'(k * pipc_pkg::FULL_SCALE))
				err_mag_c = err_mag_c + MW'(1);
		end
		err_c = diff_c[SB] ? -$signed(EW'(err_mag_c)) : $signed(EW'(err_mag_c));
	end

	always_ff @(posedge clk) begin
		if (take)
			err_s1 <= err_c;
	end

	// ------------------------------------------------------------------
	// stage 2: integrate, combine, clamp
	// ------------------------------------------------------------------
	logic signed [AW-1:0]   integ_acc_q;
	logic signed [PRODW-1:0] integ_prod_c;
	logic signed [AW:0]     acc_sum_c;
	logic signed [AW-1:0]   acc_sat_c;
	logic [AW-1:0]          acc_mag_c;
	logic [AW-1:0]          whole_mag_c;
	logic [WW-1:0]          whole_lim_c;
	logic [AW-1:0]          whole_limit_c;
	logic signed [WW-1:0]   whole_c;
	logic signed [PROPW-1:0] prop_c;
	logic signed [UW-1:0]   ctrl_c;
	logic signed [TW-1:0]   top_raw_c;
	logic signed [TW-1:0]   floor_sx_c;
	logic signed [TW-1:0]   ceil_sx_c;
	logic signed [TW-1:0]   top_lo_c;
	logic                   hit_lo_c;
	logic                   hit_hi_c;
	logic [PW-1:0]          top_c;
	logic                   hit_c;

	always_comb begin
		integ_prod_c = PRODW'($signed({1'b0, integ_gain_q})) * PRODW'(err_s1);
		acc_sum_c    = (AW+1)'(integ_acc_q) + (AW+1)'(integ_prod_c);

		// saturate the accumulator at the signed limits
		if (acc_sum_c[AW] != acc_sum_c[AW-1])
			acc_sat_c = acc_sum_c[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		else
			acc_sat_c = acc_sum_c[AW-1:0];

		// whole part toward zero, saturated to the output width
		acc_mag_c     = acc_sat_c[AW-1] ? (~acc_sat_c + AW'(1)) : acc_sat_c;
		whole_mag_c   = acc_mag_c >> pipc_pkg::FRAC_BITS;
		whole_limit_c = acc_sat_c[AW-1] ? AW'(1 << (WW-1)) : AW'((1 << (WW-1)) - 1);
		whole_lim_c   = (whole_mag_c > whole_limit_c) ? whole_limit_c[WW-1:0]
		                                              : whole_mag_c[WW-1:0];
		whole_c = acc_sat_c[AW-1] ? $signed(~whole_lim_c + WW'(1)) : $signed(whole_lim_c);

		prop_c = PROPW'($signed({1'b0, prop_gain_q})) * PROPW'(err_s1);
		ctrl_c = UW'(prop_c) + UW'(whole_c);

		top_raw_c  = $signed({3'b000, period_base_q}) - TW'(ctrl_c);
		floor_sx_c = $signed({3'b000, period_floor_q});
		ceil_sx_c  = $signed({3'b000, period_ceiling_q});

		// floor test first, ceiling second: the ceiling wins if they cross
		hit_lo_c = top_raw_c < floor_sx_c;
		top_lo_c = hit_lo_c ? floor_sx_c : top_raw_c;
		hit_hi_c = top_lo_c > ceil_sx_c;
		top_c    = hit_hi_c ? period_ceiling_q : top_lo_c[PW-1:0];
		hit_c    = hit_lo_c || hit_hi_c;
	end

	// integrator: keep the old value when the period was clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			integ_acc_q <= '0;
		else if (advance && !hit_c)
			integ_acc_q <= acc_sat_c;
	end

	logic [PW-1:0]         period_top_q;
	logic signed [WW-1:0]  integral_whole_q;
	logic signed [EW-1:0]  error_volts_q;
	logic                  clamped_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			period_top_q     <= top_c;
			integral_whole_q <= whole_c;
			error_volts_q    <= err_s1;
			clamped_q        <= hit_c;
		end
	end

	assign period_top     = period_top_q;
	assign integral_whole = integral_whole_q;
	assign error_volts    = error_volts_q;
	assign clamped        = clamped_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`PIPC_ASSERT(a_clamp_holds_integral,
		advance && hit_c |=> $stable(integ_acc_q),
		"integral moved on a clamped item")
	`PIPC_ASSERT(a_error_in_span,
		result_valid |-> (error_volts <= 4'sd5) && (error_volts >= -4'sd5),
		"error outside the volt span")
	`PIPC_ASSERT_ALWAYS(a_ready_only_when_full,
		arst_n && !sample_ready |-> s1_valid_q && out_valid_q && !result_ready,
		"input stalled while a stage was free")

endmodule
